/* design/assert_macros.svh */
// assertion macros used by the checker file pcs_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* design/pcs_pkg.sv */
`default_nettype none
package pcs_pkg;

    localparam int RAW_W   = 10;
    localparam int HIGH_W  = 11;
    localparam int VAL_W   = 7;
    localparam int IDX_W   = 2;
    localparam int NUM_W   = RAW_W + VAL_W;
    localparam int SUM_W   = VAL_W + 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - RAW_W;
    localparam int IN_PAD_W    = IN_TDATA_W - RAW_W;

    localparam int DIV_STEPS = VAL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [VAL_W-1:0]  FULL_SCALE     = 7'd127;
    localparam logic [HIGH_W-1:0] CALIB_HIGH_RST = 11'd1024;
    localparam logic [RAW_W-1:0]  CALIB_LOW_RST  = 10'd0;

    localparam logic [IDX_W-1:0] REG_CALIB_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_CALIB_HIGH = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_DIV,
        S_SMOOTH
    } t_state;

    typedef struct packed {
        logic load;
        logic scale;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

endpackage
`default_nettype wire

/* design/pcs_ctrl.sv */
`default_nettype none
module pcs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output pcs_pkg::t_dp_cmd         o_cmd,
    input  pcs_pkg::t_dp_status      i_status
);

    pcs_pkg::t_state r_state;
    pcs_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            pcs_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pcs_pkg::S_SCALE;
                end
            end
            pcs_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = pcs_pkg::S_DIV;
            end
            pcs_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = pcs_pkg::S_SMOOTH;
                end
            end
            pcs_pkg::S_SMOOTH: begin
                // wait until the result slot is free or being emptied
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = pcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

/* design/pcs_dp.sv */
`default_nettype none
module pcs_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [pcs_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [pcs_pkg::HIGH_W-1:0]   i_cfg_data,
    input  wire logic [pcs_pkg::RAW_W-1:0]    i_raw_sample,
    input  pcs_pkg::t_dp_cmd                  i_cmd,
    output pcs_pkg::t_dp_status               o_status,
    output logic [pcs_pkg::VAL_W-1:0]         o_pedal_value,
    output logic [pcs_pkg::RAW_W-1:0]         o_raw_echo,
    output logic                              o_changed
);

    logic [pcs_pkg::RAW_W-1:0]  r_calib_low;
    logic [pcs_pkg::HIGH_W-1:0] r_calib_high;

    logic [pcs_pkg::VAL_W-1:0]  r_held;
    logic [pcs_pkg::VAL_W-1:0]  r_prev;
    logic [pcs_pkg::VAL_W-1:0]  r_older;

    logic [pcs_pkg::RAW_W-1:0]  r_raw;
    logic [pcs_pkg::RAW_W-1:0]  r_diff;
    logic                       r_zero;
    logic                       r_sat;
    logic [pcs_pkg::NUM_W-1:0]  r_rem;
    logic [pcs_pkg::NUM_W-1:0]  r_div;
    logic [pcs_pkg::VAL_W-1:0]  r_quo;
    logic [pcs_pkg::CNT_W-1:0]  r_cnt;

    logic [pcs_pkg::VAL_W-1:0]  r_out_value;
    logic [pcs_pkg::RAW_W-1:0]  r_out_raw;
    logic                       r_out_changed;

    logic [pcs_pkg::HIGH_W-1:0] span;
    logic [pcs_pkg::NUM_W-1:0]  num;
    logic [pcs_pkg::NUM_W:0]    span_x128;
    logic                       rem_ge;
    logic [pcs_pkg::VAL_W-1:0]  scaled;
    logic [pcs_pkg::SUM_W-1:0]  sum;
    logic [pcs_pkg::VAL_W-1:0]  avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_low  <= pcs_pkg::CALIB_LOW_RST;
            r_calib_high <= pcs_pkg::CALIB_HIGH_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pcs_pkg::REG_CALIB_LOW) begin
                r_calib_low <= i_cfg_data[pcs_pkg::RAW_W-1:0];
            end else if (i_cfg_index == pcs_pkg::REG_CALIB_HIGH) begin
                r_calib_high <= i_cfg_data;
            end
        end
    end

    assign span      = r_calib_high - {1'b0, r_calib_low};
    // x*127 as x*128 - x
    assign num       = {r_diff, {pcs_pkg::VAL_W{1'b0}}} - {{pcs_pkg::VAL_W{1'b0}}, r_diff};
    assign span_x128 = {span, {pcs_pkg::VAL_W{1'b0}}};
    assign rem_ge    = (r_rem >= r_div);

    // operand capture, scaling and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw  <= i_raw_sample;
            r_diff <= i_raw_sample - r_calib_low;
            r_zero <= (r_calib_high <= {1'b0, r_calib_low}) || (i_raw_sample <= r_calib_low);
        end
        if (i_cmd.scale) begin
            r_rem <= num;
            r_sat <= ({1'b0, num} >= span_x128);
            r_div <= {span, {(pcs_pkg::VAL_W - 1){1'b0}}};
            r_quo <= '0;
        end else if (i_cmd.step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_quo <= {r_quo[pcs_pkg::VAL_W-2:0], rem_ge};
            r_div <= {1'b0, r_div[pcs_pkg::NUM_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.scale) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_status.div_last = (r_cnt == pcs_pkg::CNT_W'(pcs_pkg::DIV_STEPS - 1));

    always_comb begin
        if (r_zero) begin
            scaled = '0;
        end else if (r_sat) begin
            scaled = pcs_pkg::FULL_SCALE;
        end else begin
            scaled = r_quo;
        end
    end

    assign sum = {2'b00, r_held} + {2'b00, r_prev} + {2'b00, r_older} + {2'b00, scaled};
    assign avg = sum[pcs_pkg::SUM_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_prev  <= '0;
            r_older <= '0;
        end else if (i_cmd.finish && (scaled != r_held)) begin
            r_older <= r_prev;
            r_prev  <= r_held;
            if (avg != r_held) begin
                r_held <= avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_raw <= r_raw;
            if ((scaled != r_held) && (avg != r_held)) begin
                r_out_value   <= avg;
                r_out_changed <= 1'b1;
            end else begin
                r_out_value   <= r_held;
                r_out_changed <= 1'b0;
            end
        end
    end

    assign o_pedal_value = r_out_value;
    assign o_raw_echo    = r_out_raw;
    assign o_changed     = r_out_changed;

endmodule
`default_nettype wire

/* design/pedal_calibrate_and_smooth.sv */
// Pedal calibrate and smooth.
// Input stream: one raw 10-bit ADC sample per transfer on i_s_tdata. The
// block takes a sample only when it is idle, so o_s_tready drops for the
// whole of one sample's work.
// Output stream: one result per sample: smoothed pedal value 0..127, the raw
// sample echoed, and a change flag on o_m_tuser.
// Config channel: i_cfg_index 0 writes calib_low, 1 writes calib_high, other
// indexes are ignored; always ready. The user must write it only while no
// sample is in flight; the block does not enforce it. Each sample takes a
// scale step, 7 steps of restoring division (one quotient bit per cycle),
// then the averaging step that loads the output register. A new sample is
// taken only once the last one has passed the averaging step.
// The output register holds one result; the next sample is taken while it
// waits, and that sample then stalls at the averaging step until the
// receiver takes the held result. A stalled result keeps its payload.
// Reset clears the calibration to 0..1024, the history to zero and the
// output valid.
`default_nettype none
module pedal_calibrate_and_smooth (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // raw_sample[9:0], zero pad[15:10]
    input  wire logic [pcs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // pedal_value[6:0], raw_echo[16:7], zero pad[23:17]
    output logic [pcs_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // changed[0]
    output logic                                   o_m_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pcs_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire logic [pcs_pkg::HIGH_W-1:0]        i_cfg_data
);

    pcs_pkg::t_dp_cmd                cmd;
    pcs_pkg::t_dp_status             status;
    logic [pcs_pkg::VAL_W-1:0]       pedal_value;
    logic [pcs_pkg::RAW_W-1:0]       raw_echo;
    logic                            changed;

    assign o_cfg_ready = 1'b1;

    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    pcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_raw_sample  (i_s_tdata[pcs_pkg::RAW_W-1:0]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_pedal_value (pedal_value),
        .o_raw_echo    (raw_echo),
        .o_changed     (changed)
    );

    assign o_m_tdata = {{pcs_pkg::OUT_PAD_W{1'b0}}, raw_echo, pedal_value};
    assign o_m_tuser = changed;

endmodule
`default_nettype wire

/* design/pcs_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module pcs_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              o_s_tready,
    input  wire logic                              o_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [pcs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input  wire logic                              o_m_tuser
);

    // a stalled result keeps its valid and payload
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `ASSERT_CLK(a_data_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable({o_m_tdata, o_m_tuser}))

    // one sample at a time: no new transfer right after one
    `ASSERT_CLK(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready)

    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_m_tvalid)

    // a result never appears the cycle after a sample transfer
    `ASSERT_CLK(a_min_latency, i_clk, i_rst_n, i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)

endmodule

bind pedal_calibrate_and_smooth pcs_checker u_pcs_checker (.*);
`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pcs_pkg::IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [pcs_pkg::IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
    localparam int SMOOTH_TAPS   = 4;
    localparam int RAW_MAX       = 1023;
    localparam int ITEMS_PER_SET = 100;
    localparam int TAIL_CYCLES   = 24;

    typedef struct packed {
        logic [pcs_pkg::VAL_W-1:0] value;
        logic [pcs_pkg::RAW_W-1:0] raw;
        logic                      changed;
    } t_pedal_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [pcs_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [pcs_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            o_m_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pcs_pkg::IDX_W-1:0]       i_cfg_index = '0;
    logic [pcs_pkg::HIGH_W-1:0]      i_cfg_data = '0;

    // calibration and smoothing history as the block should hold them
    logic [pcs_pkg::RAW_W-1:0]  cal_low = pcs_pkg::CALIB_LOW_RST;
    logic [pcs_pkg::HIGH_W-1:0] cal_high = pcs_pkg::CALIB_HIGH_RST;
    logic [pcs_pkg::VAL_W-1:0]  held_val = '0;
    logic [pcs_pkg::VAL_W-1:0]  prev_val = '0;
    logic [pcs_pkg::VAL_W-1:0]  older_val = '0;

    logic [pcs_pkg::RAW_W-1:0] sample_q[$];
    t_pedal_result             expected_pedal_q[$];
    int                        mismatches = 0;
    int                        snd_idle_pct = 0;
    int                        rcv_idle_pct = 0;
    int                        walk = 0;

    pedal_calibrate_and_smooth dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int scale_sample(input logic [pcs_pkg::RAW_W-1:0] raw);
        int q;
        if (cal_high <= cal_low || raw <= cal_low) begin
            return 0;
        end
        q = (int'(raw) - int'(cal_low)) * int'(pcs_pkg::FULL_SCALE)
            / (int'(cal_high) - int'(cal_low));
        return (q > int'(pcs_pkg::FULL_SCALE)) ? int'(pcs_pkg::FULL_SCALE) : q;
    endfunction

    task automatic predict_pedal(input logic [pcs_pkg::RAW_W-1:0] raw);
        int scaled;
        int avg;
        t_pedal_result r;
        scaled = scale_sample(raw);
        r.changed = 1'b0;
        if (scaled != int'(held_val)) begin
            avg = (int'(older_val) + int'(prev_val) + int'(held_val) + scaled) / SMOOTH_TAPS;
            older_val = prev_val;
            prev_val = held_val;
            // history shifts even when the average lands on the held value
            if (avg != int'(held_val)) begin
                held_val = avg[pcs_pkg::VAL_W-1:0];
                r.changed = 1'b1;
            end
        end
        r.value = held_val;
        r.raw = raw;
        expected_pedal_q.push_back(r);
    endtask

    task automatic check_pedal(input logic [pcs_pkg::VAL_W-1:0] value,
                               input logic [pcs_pkg::RAW_W-1:0] raw,
                               input logic changed);
        t_pedal_result want;
        if (expected_pedal_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: value %0d raw %0d changed %0b",
                         value, raw, changed);
            end
            return;
        end
        want = expected_pedal_q.pop_front();
        if (value !== want.value || raw !== want.raw || changed !== want.changed) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: value %0d/%0d raw %0d/%0d changed %0b/%0b (exp/act)",
                         want.value, value, want.raw, raw, want.changed, changed);
            end
        end
    endtask

    // sample driver: holds tvalid until the transfer, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_pedal(i_s_tdata[pcs_pkg::RAW_W-1:0]);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {{pcs_pkg::IN_PAD_W{1'b0}}, sample_q.pop_front()};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_pedal(o_m_tdata[pcs_pkg::VAL_W-1:0],
                            o_m_tdata[pcs_pkg::VAL_W +: pcs_pkg::RAW_W], o_m_tuser);
            end
            i_m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic write_reg(input logic [pcs_pkg::IDX_W-1:0] idx,
                             input logic [pcs_pkg::HIGH_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == pcs_pkg::REG_CALIB_LOW) begin
            cal_low = data[pcs_pkg::RAW_W-1:0];
        end else if (idx == pcs_pkg::REG_CALIB_HIGH) begin
            cal_high = data;
        end
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || i_s_tvalid || expected_pedal_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_calibration(input logic [pcs_pkg::HIGH_W-1:0] low,
                                   input logic [pcs_pkg::HIGH_W-1:0] high);
        wait_drained();
        write_reg(pcs_pkg::REG_CALIB_LOW, low);
        write_reg(pcs_pkg::REG_CALIB_HIGH, high);
    endtask

    task automatic random_calibration();
        int low;
        int high;
        case ($urandom_range(0, 7))
            0: begin low = 0; high = int'(pcs_pkg::CALIB_HIGH_RST); end
            1: begin low = RAW_MAX; high = int'(pcs_pkg::CALIB_HIGH_RST); end
            2: begin low = 0; high = 1; end
            3: begin
                // empty or inverted range
                low = $urandom_range(1, RAW_MAX);
                high = $urandom_range(1, low);
            end
            default: begin
                low = $urandom_range(0, 900);
                high = $urandom_range(low + 1, int'(pcs_pkg::CALIB_HIGH_RST));
            end
        endcase
        wait_drained();
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                      pcs_pkg::HIGH_W'($urandom_range(0, 2047)));
        end
        // bit 10 of a calib_low write is not part of the register
        write_reg(pcs_pkg::REG_CALIB_LOW,
                  {1'($urandom_range(0, 7) == 0), pcs_pkg::RAW_W'(low)});
        write_reg(pcs_pkg::REG_CALIB_HIGH, pcs_pkg::HIGH_W'(high));
        walk = (low + ((high > low) ? high : RAW_MAX)) / 2;
    endtask

    // mostly a pedal sweeping slowly, with jumps, range edges and repeats
    function automatic logic [pcs_pkg::RAW_W-1:0] next_raw();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: walk = walk + int'($urandom_range(0, 48)) - 24;
            6, 7: walk = $urandom_range(0, RAW_MAX);
            8: walk = int'(cal_low) + int'($urandom_range(0, 2)) - 1;
            default: begin
                if ($urandom_range(0, 1)) begin
                    walk = int'(cal_high) + int'($urandom_range(0, 2)) - 1;
                end
            end
        endcase
        if (walk < 0) begin
            walk = 0;
        end else if (walk > RAW_MAX) begin
            walk = RAW_MAX;
        end
        return walk[pcs_pkg::RAW_W-1:0];
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 34;
        rcv_idle_pct = 69;

        // default calibration: extremes and alternating bit patterns
        sample_q = '{10'd0, 10'd1023, 10'd1023, 10'd1023, 10'h155, 10'h2aa, 10'd0};
        // sample at, below and above the range
        set_calibration(11'd100, 11'd900);
        sample_q = '{10'd100, 10'd50, 10'd1000, 10'd900, 10'd500};
        // inverted range, then empty range
        set_calibration(11'd1023, 11'd5);
        sample_q = '{10'd700, 10'd1023};
        set_calibration(11'd500, 11'd500);
        sample_q = '{10'd500, 10'd800};
        // writes to unmapped indexes must leave the calibration alone
        wait_drained();
        write_reg(REG_UNMAPPED_LO, 11'h7ff);
        write_reg(REG_UNMAPPED_HI, 11'h000);
        set_calibration(11'd0, 11'd1);
        sample_q = '{10'd0, 10'd1, 10'd2};
        set_calibration(11'd1023, 11'd1024);
        sample_q = '{10'd1022, 10'd1023};

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin snd_idle_pct = 34; rcv_idle_pct = 69; end
                1: begin snd_idle_pct = 69; rcv_idle_pct = 34; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int set = 0; set < 3; set++) begin
                random_calibration();
                for (int n = 0; n < ITEMS_PER_SET; n++) begin
                    sample_q.push_back(next_raw());
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_pedal_q.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", expected_pedal_q.size());
        end
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule
